### rtl/core/dqs_pkg.sv
// ----------------------------------------------------------------------------
// dqs_pkg
// Shared types and codes for the deque with linear search.
// ----------------------------------------------------------------------------
package dqs_pkg;

   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_SEARCH     = 3'd4;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam int unsigned VALUE_WIDTH = 32;
   localparam int unsigned COUNT_WIDTH = 5;

   typedef struct packed {
      logic [2:0]                    command;
      logic signed [VALUE_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic                   found;
      logic [COUNT_WIDTH-1:0] count;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

### rtl/core/deque_with_search_top.sv
// Push, pop, unused command codes and a search of an empty queue need no
// scan; the result is registered and shown the cycle after acceptance.
// A search reads the ring memory one entry per cycle from the front, ending
// early on the first match. One item is in work at a time. Synchronous
// reset empties the queue; the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
// deque_with_search_top
// Bounded double-ended queue of signed 32-bit values in a ring memory, with
// push/pop at both ends and a linear search over the held entries.
// ----------------------------------------------------------------------------
module deque_with_search_top #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dqs_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dqs_pkg::rsp_type rsp_item
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
      return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] i);
      return (i == '0) ? IW'(DEPTH - 1) : i - 1'b1;
   endfunction

   dqs_pkg::state_type state_ff, state_in;
   logic [IW-1:0]      front_ff, front_in;
   logic [IW-1:0]      back_ff, back_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      issued_ff, issued_in;
   logic signed [dqs_pkg::VALUE_WIDTH-1:0] key_ff, key_in;
   logic               rsp_valid_ff, rsp_valid_in;
   dqs_pkg::rsp_type   rsp_ff, rsp_in;

   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   logic [IW-1:0]      rd_addr;
   logic [dqs_pkg::VALUE_WIDTH-1:0] rd_data;

   logic               accept;
   logic               full;
   logic               empty;
   logic [CW+dqs_pkg::COUNT_WIDTH-1:0] count_ext;

   dqs_ram #(
      .WIDTH (dqs_pkg::VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_item.value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == dqs_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dqs_pkg::ST_IDLE;
         front_ff     <= '0;
         back_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff    <= pos_in;
      issued_ff <= issued_in;
      key_ff    <= key_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      issued_in    = issued_ff;
      key_in       = key_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_addr      = back_ff;
      rd_addr      = (state_ff == dqs_pkg::ST_SCAN) ? pos_ff : front_ff;
      count_ext    = '0;

      case (state_ff)
         dqs_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_in.status = dqs_pkg::STATUS_DONE;
               rsp_in.found  = 1'b0;
               rsp_valid_in  = 1'b1;
               case (req_item.command)
                  dqs_pkg::CMD_PUSH_FRONT: begin
                     if (full) begin
                        rsp_in.status = dqs_pkg::STATUS_FULL;
                     end else begin
                        front_in = ring_prev(front_ff);
                        wr_en    = 1'b1;
                        wr_addr  = ring_prev(front_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  dqs_pkg::CMD_PUSH_BACK: begin
                     if (full) begin
                        rsp_in.status = dqs_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = back_ff;
                        back_in  = ring_next(back_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  dqs_pkg::CMD_POP_FRONT: begin
                     if (empty) begin
                        rsp_in.status = dqs_pkg::STATUS_EMPTY;
                     end else begin
                        front_in = ring_next(front_ff);
                        count_in = count_ff - 1'b1;
                     end
                  end
                  dqs_pkg::CMD_POP_BACK: begin
                     if (empty) begin
                        rsp_in.status = dqs_pkg::STATUS_EMPTY;
                     end else begin
                        back_in  = ring_prev(back_ff);
                        count_in = count_ff - 1'b1;
                     end
                  end
                  dqs_pkg::CMD_SEARCH: begin
                     // front entry is being read now; walk on from the next one
                     if (!empty) begin
                        rsp_valid_in = 1'b0;
                        key_in       = req_item.value;
                        pos_in       = ring_next(front_ff);
                        issued_in    = CW'(1);
                        state_in     = dqs_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
               count_ext    = {{dqs_pkg::COUNT_WIDTH{1'b0}}, count_in};
               rsp_in.count = count_ext[dqs_pkg::COUNT_WIDTH-1:0];
            end
         end
         dqs_pkg::ST_SCAN: begin
            // rd_data holds the entry of the last issued read
            if ((rd_data == key_ff) || (issued_ff == count_ff)) begin
               count_ext     = {{dqs_pkg::COUNT_WIDTH{1'b0}}, count_ff};
               rsp_in.status = dqs_pkg::STATUS_DONE;
               rsp_in.found  = (rd_data == key_ff);
               rsp_in.count  = count_ext[dqs_pkg::COUNT_WIDTH-1:0];
               rsp_valid_in  = 1'b1;
               state_in      = dqs_pkg::ST_IDLE;
            end else begin
               pos_in    = ring_next(pos_ff);
               issued_in = issued_ff + 1'b1;
            end
         end
         default: begin
            state_in = dqs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/core/dqs_ram.sv
// ----------------------------------------------------------------------------
// dqs_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module dqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
